// ===== hw/rtl/text_console_char_writer_defines.svh =====
// ----------------------------------------------------------------------------
// Text console character writer: assertion macros
// Property wrappers for the checker file.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH

// check a property while out of reset
`define TCCW_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// check a property at every edge, reset included
`define TCCW_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/tccw_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console character writer package
// Geometry, character codes, payload layouts and controller interface types.
// ----------------------------------------------------------------------------
package tccw_pkg;

  localparam int NUM_COLS   = 80;
  localparam int NUM_ROWS   = 23;
  localparam int CELLS      = NUM_COLS * NUM_ROWS;
  localparam int COPY_CELLS = (NUM_ROWS - 1) * NUM_COLS;
  localparam int ADDR_W     = $clog2(CELLS);

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int LIN_W  = 11;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = CHAR_W + ATTR_W;
  localparam int IN_PAD_W = 4;
  localparam int IN_DATA_W  = CHAR_W + ATTR_W + ROW_W + COL_W + IN_PAD_W;
  localparam int OUT_DATA_W = COL_W + ROW_W + LIN_W + CELL_W + 1;

  localparam logic [CHAR_W-1:0] CHAR_BLANK     = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
  localparam logic [ATTR_W-1:0] ATTR_RESET     = 8'h07;
  localparam logic [ATTR_W-1:0] DEFAULT_COLOR_RESET = 8'h0F;

  typedef enum logic {
    OP_PUT  = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef struct packed {
    logic [IN_PAD_W-1:0] pad;
    logic [COL_W-1:0]    read_col;
    logic [ROW_W-1:0]    read_row;
    logic [ATTR_W-1:0]   color;
    logic [CHAR_W-1:0]   char_code;
  } in_data_t;

  typedef struct packed {
    logic              scrolled;
    logic [CELL_W-1:0] cell_data;
    logic [LIN_W-1:0]  cursor_linear;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
  } out_data_t;

  typedef struct packed {
    logic clear_wr;
    logic latch_in;
    logic exec_put;
    logic read_item;
    logic copy_step;
    logic fill_step;
    logic idx_clr;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_read;
    logic scroll_req;
    logic copy_last;
    logic fill_last;
    logic out_busy;
  } sts_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(NUM_COLS) + ADDR_W'(col);
  endfunction

  function automatic logic [LIN_W-1:0] cursor_lin(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return LIN_W'(row) * LIN_W'(NUM_COLS) + LIN_W'(col);
  endfunction

endpackage

// ===== hw/rtl/tccw_datapath.sv =====
// ----------------------------------------------------------------------------
// Text console datapath
// Cell memory, cursor, item registers, clear/scroll index counter and output register.
// ----------------------------------------------------------------------------
module tccw_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tccw_pkg::cmd_t                   cmd_i,
  output tccw_pkg::sts_t                   sts_o,
  input  logic [tccw_pkg::IN_DATA_W-1:0]   s_tdata_i,
  input  logic                             s_tuser_i,
  input  logic                             cfg_wr_en_i,
  input  logic [tccw_pkg::ATTR_W-1:0]      cfg_wr_data_i,
  input  logic                             m_tready_i,
  output logic                             m_tvalid_o,
  output logic [tccw_pkg::OUT_DATA_W-1:0]  m_tdata_o
);

  localparam int CW = tccw_pkg::COL_W;
  localparam int RW = tccw_pkg::ROW_W;
  localparam int AW = tccw_pkg::ADDR_W;

  tccw_pkg::in_data_t  in_d;
  tccw_pkg::op_e       op_q;
  logic [tccw_pkg::CHAR_W-1:0] char_q;
  logic [tccw_pkg::ATTR_W-1:0] color_q;
  logic [RW-1:0]       rrow_q;
  logic [CW-1:0]       rcol_q;
  logic [CW-1:0]       cur_col_q;
  logic [RW-1:0]       cur_row_q;
  logic [tccw_pkg::ATTR_W-1:0] dflt_q;
  logic [AW-1:0]       idx_q;
  logic                scrolled_q;
  logic [tccw_pkg::CELL_W-1:0] rdata_q;
  logic                m_tvalid_q;
  tccw_pkg::out_data_t m_tdata_q;
  tccw_pkg::out_data_t out_d;

  logic [tccw_pkg::CELL_W-1:0] cell_mem [tccw_pkg::CELLS];

  logic [tccw_pkg::ATTR_W-1:0] attr;
  logic [CW:0]         col_n;
  logic [RW:0]         row_n;
  logic                put_we;
  logic [AW-1:0]       put_addr;
  logic [tccw_pkg::CELL_W-1:0] put_data;
  logic                scroll_req;
  logic                in_range;

  logic                mem_we;
  logic [AW-1:0]       mem_wa;
  logic [tccw_pkg::CELL_W-1:0] mem_wd;
  logic                mem_re;
  logic [AW-1:0]       mem_ra;

  assign in_d = tccw_pkg::in_data_t'(s_tdata_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q    <= tccw_pkg::op_e'(s_tuser_i);
      char_q  <= in_d.char_code;
      color_q <= in_d.color;
      rrow_q  <= in_d.read_row;
      rcol_q  <= in_d.read_col;
    end
  end

  // put: next cursor and cell write
  always_comb begin
    attr     = (color_q == '0) ? dflt_q : color_q;
    col_n    = {1'b0, cur_col_q};
    row_n    = {1'b0, cur_row_q};
    put_we   = 1'b0;
    put_addr = tccw_pkg::cell_addr(cur_row_q, cur_col_q);
    put_data = {attr, char_q};
    if (char_q == tccw_pkg::CHAR_NEWLINE) begin
      col_n = '0;
      row_n = {1'b0, cur_row_q} + (RW+1)'(1);
    end else if (char_q == tccw_pkg::CHAR_BACKSPACE) begin
      if (cur_col_q != '0) begin
        col_n    = {1'b0, cur_col_q} - (CW+1)'(1);
        put_we   = 1'b1;
        put_addr = tccw_pkg::cell_addr(cur_row_q, cur_col_q - CW'(1));
        put_data = {attr, tccw_pkg::CHAR_BLANK};
      end
    end else begin
      put_we = 1'b1;
      col_n  = {1'b0, cur_col_q} + (CW+1)'(1);
    end
    if (col_n >= (CW+1)'(tccw_pkg::NUM_COLS)) begin
      col_n = '0;
      row_n = row_n + (RW+1)'(1);
    end
    scroll_req = row_n >= (RW+1)'(tccw_pkg::NUM_ROWS);
  end

  assign in_range = (32'(rrow_q) < tccw_pkg::NUM_ROWS) && (32'(rcol_q) < tccw_pkg::NUM_COLS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q <= '0;
      cur_row_q <= '0;
      dflt_q    <= tccw_pkg::DEFAULT_COLOR_RESET;
      idx_q     <= '0;
    end else begin
      if (cmd_i.exec_put) begin
        cur_col_q <= col_n[CW-1:0];
        cur_row_q <= scroll_req ? RW'(tccw_pkg::NUM_ROWS - 1) : row_n[RW-1:0];
      end
      if (cfg_wr_en_i) begin
        dflt_q <= cfg_wr_data_i;
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.clear_wr || cmd_i.copy_step || cmd_i.fill_step) begin
        idx_q <= idx_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      scrolled_q <= 1'b0;
    end else if (cmd_i.exec_put) begin
      scrolled_q <= scroll_req;
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_q;
    mem_wd = {tccw_pkg::ATTR_RESET, tccw_pkg::CHAR_BLANK};
    if (cmd_i.clear_wr) begin
      mem_we = 1'b1;
    end else if (cmd_i.exec_put) begin
      mem_we = put_we;
      mem_wa = put_addr;
      mem_wd = put_data;
    end else if (cmd_i.copy_step) begin
      mem_we = idx_q != '0;
      mem_wa = idx_q - AW'(1);
      mem_wd = rdata_q;
    end else if (cmd_i.fill_step) begin
      mem_we = 1'b1;
      mem_wa = AW'(tccw_pkg::COPY_CELLS) + idx_q;
      mem_wd = {dflt_q, tccw_pkg::CHAR_BLANK};
    end
  end

  always_comb begin
    mem_re = 1'b0;
    mem_ra = tccw_pkg::cell_addr(rrow_q, rcol_q);
    if (cmd_i.read_item) begin
      mem_re = in_range;
    end else if (cmd_i.copy_step) begin
      mem_re = idx_q < AW'(tccw_pkg::COPY_CELLS);
      mem_ra = idx_q + AW'(tccw_pkg::NUM_COLS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cell_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= cell_mem[mem_ra];
    end
  end

  always_comb begin
    out_d.cursor_col    = cur_col_q;
    out_d.cursor_row    = cur_row_q;
    out_d.cursor_linear = tccw_pkg::cursor_lin(cur_row_q, cur_col_q);
    out_d.cell_data     = (op_q == tccw_pkg::OP_READ && in_range) ? rdata_q : '0;
    out_d.scrolled      = scrolled_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      m_tvalid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      m_tdata_q <= out_d;
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = m_tdata_q;

  assign sts_o.clear_last = idx_q == AW'(tccw_pkg::CELLS - 1);
  assign sts_o.is_read    = op_q == tccw_pkg::OP_READ;
  assign sts_o.scroll_req = scroll_req;
  assign sts_o.copy_last  = idx_q == AW'(tccw_pkg::COPY_CELLS);
  assign sts_o.fill_last  = idx_q == AW'(tccw_pkg::NUM_COLS - 1);
  assign sts_o.out_busy   = m_tvalid_q;

endmodule

// ===== hw/rtl/tccw_ctrl.sv =====
// ----------------------------------------------------------------------------
// Text console controller
// Sequences memory clear, item execution, scroll copy/fill and result load.
// ----------------------------------------------------------------------------
module tccw_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_tvalid_i,
  output logic           s_tready_o,
  input  logic           m_tready_i,
  input  tccw_pkg::sts_t sts_i,
  output tccw_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_COPY   = 3'd3;
  localparam logic [2:0] S_FILL   = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_free;
  logic       s_tready;

  assign out_free = !sts_i.out_busy || m_tready_i;

  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    s_tready = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (sts_i.clear_last) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.is_read) begin
          cmd_o.read_item = 1'b1;
          state_d         = S_RESULT;
        end else begin
          cmd_o.exec_put = 1'b1;
          state_d        = sts_i.scroll_req ? S_COPY : S_RESULT;
        end
      end
      S_COPY: begin
        cmd_o.copy_step = 1'b1;
        if (sts_i.copy_last) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = S_FILL;
        end
      end
      S_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (sts_i.fill_last) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          s_tready       = 1'b1;
          if (s_tvalid_i) begin
            cmd_o.latch_in = 1'b1;
            state_d        = S_EXEC;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_tready_o = s_tready;

endmodule

// ===== hw/rtl/text_console_char_writer.sv =====
// ----------------------------------------------------------------------------
// Text console character writer
// Writes characters into a row/column cell store with cursor and scrolling.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one item per transfer; tuser is the operation (put or read),
//     tdata carries char_code, color, read_row and read_col.
//   m_axis: one result per item; tdata carries cursor_col, cursor_row,
//     cursor_linear, cell_data and scrolled.
//   cfg_wr_en_i / cfg_wr_data_i: write the default color while idle.
// Sequence:
//   A put or a read registers the item, accesses the cell memory and loads
//   the result; the next item is taken as that result is loaded. A put that
//   scrolls adds a copy pass that moves rows 1 to rows-1 up by one row and a
//   fill pass that writes the last row with blanks in the default color.
// Reset:
//   Clear the store to blank cells with attribute 0x07 with s_axis_tready_o
//   low; cursor to 0,0, default color to 0x0F.
// Stall:
//   Hold a result in the output register; load the next result only once that
//   register is free or being drained, though an item may be taken while idle.
module text_console_char_writer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // char_code[7:0], color[15:8], read_row[20:16], read_col[27:21], zero[31:28]
  input  logic [tccw_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // op[0]
  input  logic                            s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // cursor_col[6:0], cursor_row[11:7], cursor_linear[22:12], cell_data[38:23],
  // scrolled[39]
  output logic [tccw_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input  logic                            cfg_wr_en_i,
  input  logic [tccw_pkg::ATTR_W-1:0]     cfg_wr_data_i
);

  tccw_pkg::cmd_t cmd;
  tccw_pkg::sts_t sts;

  tccw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .m_tready_i (m_axis_tready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tccw_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .s_tdata_i     (s_axis_tdata_i),
    .s_tuser_i     (s_axis_tuser_i),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .m_tready_i    (m_axis_tready_i),
    .m_tvalid_o    (m_axis_tvalid_o),
    .m_tdata_o     (m_axis_tdata_o)
  );

endmodule

// ===== hw/rtl/tccw_checker.sv =====
// ----------------------------------------------------------------------------
// Text console checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_console_char_writer_defines.svh"

module tccw_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [tccw_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  tccw_pkg::out_data_t res;

  assign res = tccw_pkg::out_data_t'(m_axis_tdata_o);

  `TCCW_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o, "result dropped while stalled")
  `TCCW_ASSERT(a_out_stable, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o), "result changed while stalled")
  `TCCW_ASSERT(a_linear, clk_i, rst_ni, m_axis_tvalid_o |-> res.cursor_linear == tccw_pkg::cursor_lin(res.cursor_row, res.cursor_col), "cursor_linear mismatch")
  `TCCW_ASSERT(a_scroll_row, clk_i, rst_ni, m_axis_tvalid_o && res.scrolled |-> (res.cursor_row == tccw_pkg::ROW_W'(tccw_pkg::NUM_ROWS - 1)) && (res.cell_data == '0), "scroll left cursor off last row")
  `TCCW_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !m_axis_tvalid_o, "result valid in reset")

endmodule

bind text_console_char_writer tccw_checker u_tccw_checker (.*);

// ===== sim/text_console_char_writer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text console character writer testbench
// Drives put and read transfers through the stream ports with random gaps
// and back-pressure. A shadow copy of the cell store and cursor predicts each
// result not typed in the directed table of corner cases; then random text
// runs with newlines, backspaces and reads go through several default colors.
// ----------------------------------------------------------------------------
module text_console_char_writer_tb;
  import tccw_pkg::*;

  localparam int DIR_N = 23;
  localparam int PHASES = 5;
  localparam int PHASE_ITEMS = 196;

  typedef struct {
    op_e              op;
    logic [7:0]       ch;
    logic [7:0]       colr;
    logic [4:0]       rrow;
    logic [6:0]       rcol;
    int               reps;
    bit               chk;
    logic [6:0]       ecol;
    logic [4:0]       erow;
    logic [10:0]      elin;
    logic [15:0]      ecell;
    logic             escr;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_en;
  logic [ATTR_W-1:0]     cfg_data;

  logic [CELL_W-1:0] screen_mem [CELLS];
  int                caret_col;
  int                caret_row;
  logic [7:0]        dflt_attr;
  out_data_t         pending_results [$];
  int                fault_count;
  bit                idle_on;
  int                stall_left;

  dir_row_t dir_tab [DIR_N] = '{
    '{OP_READ, 8'h00, 8'h00, 5'd0,  7'd0,   1,  1'b1, 7'd0, 5'd0,  11'd0,    16'h0720, 1'b0},
    '{OP_READ, 8'h00, 8'h00, 5'd22, 7'd79,  1,  1'b1, 7'd0, 5'd0,  11'd0,    16'h0720, 1'b0},
    '{OP_READ, 8'h00, 8'h00, 5'd23, 7'd0,   1,  1'b1, 7'd0, 5'd0,  11'd0,    16'h0000, 1'b0},
    '{OP_READ, 8'hFF, 8'hFF, 5'd31, 7'd127, 1,  1'b1, 7'd0, 5'd0,  11'd0,    16'h0000, 1'b0},
    '{OP_READ, 8'h00, 8'h00, 5'd0,  7'd80,  1,  1'b1, 7'd0, 5'd0,  11'd0,    16'h0000, 1'b0},
    '{OP_PUT, CHAR_BACKSPACE, 8'h00, 5'd0, 7'd0, 1, 1'b1, 7'd0, 5'd0, 11'd0, 16'h0000, 1'b0},
    '{OP_PUT,  8'h41, 8'h00, 5'd0,  7'd0,   1,  1'b1, 7'd1, 5'd0,  11'd1,    16'h0000, 1'b0},
    '{OP_PUT,  8'h00, 8'hFF, 5'd31, 7'd127, 1,  1'b1, 7'd2, 5'd0,  11'd2,    16'h0000, 1'b0},
    '{OP_PUT,  8'hFF, 8'h80, 5'd0,  7'd0,   1,  1'b1, 7'd3, 5'd0,  11'd3,    16'h0000, 1'b0},
    '{OP_PUT, CHAR_BACKSPACE, 8'h1E, 5'd0, 7'd0, 1, 1'b1, 7'd2, 5'd0, 11'd2, 16'h0000, 1'b0},
    '{OP_READ, 8'h00, 8'h00, 5'd0,  7'd2,   1,  1'b1, 7'd2, 5'd0,  11'd2,    16'h1E20, 1'b0},
    '{OP_READ, 8'h00, 8'h00, 5'd0,  7'd0,   1,  1'b1, 7'd2, 5'd0,  11'd2,    16'h0F41, 1'b0},
    '{OP_READ, 8'h00, 8'h00, 5'd0,  7'd1,   1,  1'b1, 7'd2, 5'd0,  11'd2,    16'hFF00, 1'b0},
    '{OP_PUT, CHAR_NEWLINE, 8'h00, 5'd0, 7'd0, 1, 1'b1, 7'd0, 5'd1, 11'd80, 16'h0000, 1'b0},
    '{OP_PUT, CHAR_NEWLINE, 8'h00, 5'd0, 7'd0, 21, 1'b0, 7'd0, 5'd0, 11'd0,  16'h0000, 1'b0},
    '{OP_PUT,  8'h5A, 8'h2A, 5'd0,  7'd0,   79, 1'b0, 7'd0, 5'd0,  11'd0,    16'h0000, 1'b0},
    '{OP_PUT,  8'h7A, 8'h01, 5'd0,  7'd0,   1,  1'b1, 7'd0, 5'd22, 11'd1760, 16'h0000, 1'b1},
    '{OP_READ, 8'h00, 8'h00, 5'd21, 7'd0,   1,  1'b1, 7'd0, 5'd22, 11'd1760, 16'h2A5A, 1'b0},
    '{OP_READ, 8'h00, 8'h00, 5'd21, 7'd79,  1,  1'b1, 7'd0, 5'd22, 11'd1760, 16'h017A, 1'b0},
    '{OP_READ, 8'h00, 8'h00, 5'd22, 7'd5,   1,  1'b1, 7'd0, 5'd22, 11'd1760, 16'h0F20, 1'b0},
    '{OP_PUT, CHAR_NEWLINE, 8'h00, 5'd0, 7'd0, 1, 1'b1, 7'd0, 5'd22, 11'd1760, 16'h0000, 1'b1},
    '{OP_READ, 8'h00, 8'h00, 5'd20, 7'd0,   1,  1'b1, 7'd0, 5'd22, 11'd1760, 16'h2A5A, 1'b0},
    '{OP_PUT, CHAR_BACKSPACE, 8'h33, 5'd0, 7'd0, 1, 1'b1, 7'd0, 5'd22, 11'd1760, 16'h0000, 1'b0}
  };

  text_console_char_writer uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_wr_en_i     (cfg_en),
    .cfg_wr_data_i   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic out_data_t next_console_result(op_e op, logic [7:0] ch,
                                                    logic [7:0] colr, logic [4:0] rrow,
                                                    logic [6:0] rcol);
    out_data_t  res;
    logic [7:0] attr;
    res = '0;
    if (op == OP_READ) begin
      if (int'(rrow) < NUM_ROWS && int'(rcol) < NUM_COLS) begin
        res.cell_data = screen_mem[int'(rrow) * NUM_COLS + int'(rcol)];
      end
    end else begin
      attr = (colr == 8'h00) ? dflt_attr : colr;
      if (ch == CHAR_NEWLINE) begin
        caret_col = 0;
        caret_row++;
      end else if (ch == CHAR_BACKSPACE) begin
        if (caret_col > 0) begin
          caret_col--;
          screen_mem[caret_row * NUM_COLS + caret_col] = {attr, CHAR_BLANK};
        end
      end else begin
        screen_mem[caret_row * NUM_COLS + caret_col] = {attr, ch};
        caret_col++;
      end
      if (caret_col >= NUM_COLS) begin
        caret_col = 0;
        caret_row++;
      end
      if (caret_row >= NUM_ROWS) begin
        for (int i = 0; i < COPY_CELLS; i++) screen_mem[i] = screen_mem[i + NUM_COLS];
        for (int i = COPY_CELLS; i < CELLS; i++) screen_mem[i] = {dflt_attr, CHAR_BLANK};
        caret_row = NUM_ROWS - 1;
        res.scrolled = 1'b1;
      end
    end
    res.cursor_col    = 7'(caret_col);
    res.cursor_row    = 5'(caret_row);
    res.cursor_linear = 11'(caret_row * NUM_COLS + caret_col);
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  task automatic note_mismatch(string field, longint unsigned want, longint unsigned got);
    fault_count++;
    if (fault_count <= 10) begin
      $display("mismatch on %s: expected 0x%0h, got 0x%0h", field, want, got);
    end
  endtask

  task automatic send_item(op_e op, logic [7:0] ch, logic [7:0] colr, logic [4:0] rrow,
                           logic [6:0] rcol, bit chk, out_data_t typed);
    in_data_t  d;
    out_data_t pred;
    int        g;
    g = pick_gap();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    d           = '0;
    d.char_code = ch;
    d.color     = colr;
    d.read_row  = rrow;
    d.read_col  = rcol;
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    pred = next_console_result(op, ch, colr, rrow, rcol);
    pending_results.push_back(chk ? typed : pred);
  endtask

  task automatic write_default_color(logic [7:0] v);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_en   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_en    <= 1'b0;
    dflt_attr = v;
  endtask

  // result side: check on transfer, then pick the next ready level
  always @(posedge clk) begin
    out_data_t got;
    out_data_t want;
    if (rst_n && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_results.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) $display("result 0x%0h with nothing pending", got);
      end else begin
        want = pending_results.pop_front();
        if (got.cursor_col !== want.cursor_col)
          note_mismatch("cursor_col", want.cursor_col, got.cursor_col);
        if (got.cursor_row !== want.cursor_row)
          note_mismatch("cursor_row", want.cursor_row, got.cursor_row);
        if (got.cursor_linear !== want.cursor_linear)
          note_mismatch("cursor_linear", want.cursor_linear, got.cursor_linear);
        if (got.cell_data !== want.cell_data)
          note_mismatch("cell_data", want.cell_data, got.cell_data);
        if (got.scrolled !== want.scrolled)
          note_mismatch("scrolled", want.scrolled, got.scrolled);
      end
    end
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
      if (idle_on && $urandom_range(0, 99) < 25) stall_left = pick_gap();
    end
  end

  initial begin
    #100_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    out_data_t  typed;
    op_e        op;
    logic [7:0] ch;
    logic [7:0] colr;
    logic [4:0] rrow;
    logic [6:0] rcol;
    logic [7:0] phase_color;
    int         sel;

    rst_n       = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = 1'b0;
    cfg_en      = 1'b0;
    cfg_data    = '0;
    idle_on     = 1'b1;
    caret_col   = 0;
    caret_row   = 0;
    dflt_attr   = DEFAULT_COLOR_RESET;
    for (int i = 0; i < CELLS; i++) screen_mem[i] = {ATTR_RESET, CHAR_BLANK};
    #1;
    rst_n = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      typed               = '0;
      typed.cursor_col    = dir_tab[i].ecol;
      typed.cursor_row    = dir_tab[i].erow;
      typed.cursor_linear = dir_tab[i].elin;
      typed.cell_data     = dir_tab[i].ecell;
      typed.scrolled      = dir_tab[i].escr;
      repeat (dir_tab[i].reps) begin
        send_item(dir_tab[i].op, dir_tab[i].ch, dir_tab[i].colr, dir_tab[i].rrow,
                  dir_tab[i].rcol, dir_tab[i].chk, typed);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      s_tvalid <= 1'b0;
      case (ph)
        0: phase_color = 8'h00;
        1: phase_color = 8'hFF;
        4: phase_color = DEFAULT_COLOR_RESET;
        default: phase_color = 8'($urandom_range(1, 254));
      endcase
      write_default_color(phase_color);
      idle_on = (ph != 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        sel  = $urandom_range(0, 99);
        colr = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
        rrow = 5'($urandom_range(0, 31));
        rcol = 7'($urandom_range(0, 127));
        ch   = 8'($urandom_range(0, 255));
        if (sel < 14) begin
          op = OP_READ;
          if ($urandom_range(0, 4) != 0) begin
            rrow = 5'($urandom_range(0, NUM_ROWS - 1));
            rcol = 7'($urandom_range(0, NUM_COLS - 1));
          end
        end else begin
          op = OP_PUT;
          if (sel < 20) ch = CHAR_NEWLINE;
          else if (sel < 27) ch = CHAR_BACKSPACE;
          else if (sel < 85) ch = 8'($urandom_range(8'h20, 8'h7E));
        end
        send_item(op, ch, colr, rrow, rcol, 1'b0, '0);
      end
    end
    s_tvalid <= 1'b0;
    idle_on = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fault_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
